// File: sv/rdm_frame_parser_defines.svh
// Assertion macros shared by the frame parser RTL.
`ifndef RDM_FRAME_PARSER_DEFINES_SVH
`define RDM_FRAME_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define RDM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdm assertion failed");
// Next-cycle implication, disabled during reset
`define RDM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdm assertion failed");
`else
`define RDM_ASSERT_IMP(label, clk, rst, ante, cons)
`define RDM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// File: sv/rdm_pkg.sv
// Package: frame parser constants, state encoding and result type.
`timescale 1ns / 1ps
package rdm_pkg;

  // Result kinds
  localparam logic [1:0] KIND_REJECT = 2'd0;
  localparam logic [1:0] KIND_DISC   = 2'd1;
  localparam logic [1:0] KIND_MSG    = 2'd2;

  // Start codes and framing bytes
  localparam logic [7:0] START_PREAMBLE = 8'hFE;
  localparam logic [7:0] DELIMITER      = 8'hAA;
  localparam logic [7:0] START_MSG      = 8'hCC;
  localparam logic [7:0] SUB_START      = 8'h01;

  // Interleave masks and per-byte bias for discovery checksum
  localparam logic [7:0] PAIR_LO_MASK = 8'h55;
  localparam logic [7:0] PAIR_HI_MASK = 8'hAA;
  localparam logic [7:0] BYTE_BIAS    = 8'hFF;

  localparam logic [2:0] MAX_PREAMBLE  = 3'd7;
  localparam logic [9:0] MIN_DISC_SIZE = 10'd17;
  localparam logic [9:0] MSG_HDR_SIZE  = 10'd24;
  localparam logic [8:0] INDEX_MAX     = 9'd511;

  // Fixed fields reported for discovery responses
  localparam logic [7:0]  DISC_CMD_CLASS = 8'h11;
  localparam logic [15:0] DISC_PARAM_ID  = 16'h0001;

  // Frame tracking state
  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_DISC = 4'b0010,
    MODE_MSG  = 4'b0100,
    MODE_REJ  = 4'b1000
  } rdm_mode_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic        checksum_ok;
    logic [47:0] source_id;
    logic [47:0] destination_id;
    logic [7:0]  transaction_number;
    logic [7:0]  port_or_response;
    logic [7:0]  queued_count;
    logic [15:0] subdevice_num;
    logic [7:0]  command_class;
    logic [15:0] parameter_id;
    logic [7:0]  data_length;
  } rdm_result_t;

endpackage

// File: sv/rdm_if.sv
// Interfaces: byte input channel and frame result channel.
`timescale 1ns / 1ps
interface rdm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_last;

  modport source (output valid, output rx_byte, output frame_last, input ready);
  modport sink   (input valid, input rx_byte, input frame_last, output ready);
endinterface

interface rdm_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_kind;
  logic        checksum_ok;
  logic [47:0] source_id;
  logic [47:0] destination_id;
  logic [7:0]  transaction_number;
  logic [7:0]  port_or_response;
  logic [7:0]  queued_count;
  logic [15:0] subdevice_num;
  logic [7:0]  command_class;
  logic [15:0] parameter_id;
  logic [7:0]  data_length;

  modport source (output valid, output frame_kind, output checksum_ok, output source_id,
                  output destination_id, output transaction_number,
                  output port_or_response, output queued_count, output subdevice_num,
                  output command_class, output parameter_id, output data_length,
                  input ready);
  modport sink   (input valid, input frame_kind, input checksum_ok, input source_id,
                  input destination_id, input transaction_number,
                  input port_or_response, input queued_count, input subdevice_num,
                  input command_class, input parameter_id, input data_length,
                  output ready);
endinterface

// File: sv/rdm_frame_track.sv
// Per-frame state tracker: byte counter, field capture and checksum.
`timescale 1ns / 1ps
`include "rdm_frame_parser_defines.svh"
module rdm_frame_track (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  input  logic               frame_last,
  output logic               frame_done,
  output rdm_pkg::rdm_result_t result
);
  import rdm_pkg::*;

  rdm_mode_t   frame_mode, frame_mode_next, mode_cur;
  logic [8:0]  byte_index;
  logic [2:0]  preamble_count, preamble_count_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  declared_length, declared_length_next;
  logic [15:0] received_checksum, received_checksum_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [47:0] source_reg, source_reg_next;
  logic [47:0] destination_reg, destination_reg_next;
  logic [63:0] header_fields, header_fields_next;

  logic [8:0]  disc_off;
  logic [7:0]  pair_val;
  logic [7:0]  len_eff;
  logic [9:0]  frame_size;
  logic        disc_good, msg_good;

  assign disc_off   = byte_index - {6'd0, preamble_count} - 9'd1;
  assign pair_val   = (held_byte & PAIR_LO_MASK) | (rx_byte & PAIR_HI_MASK);
  assign len_eff    = (byte_index == 9'd2) ? rx_byte : declared_length;
  assign frame_size = {1'b0, byte_index} + 10'd1;

  // Next state for one byte
  always_comb begin
    mode_cur               = frame_mode;
    preamble_count_next    = preamble_count;
    running_sum_next       = running_sum;
    declared_length_next   = declared_length;
    received_checksum_next = received_checksum;
    held_byte_next         = held_byte;
    source_reg_next        = source_reg;
    destination_reg_next   = destination_reg;
    header_fields_next     = header_fields;

    // start code picks the frame type
    if (frame_mode == MODE_IDLE) begin
      if (rx_byte == START_PREAMBLE || rx_byte == DELIMITER) mode_cur = MODE_DISC;
      else if (rx_byte == START_MSG) mode_cur = MODE_MSG;
      else mode_cur = MODE_REJ;
    end
    frame_mode_next = mode_cur;

    if (mode_cur == MODE_DISC) begin
      // preamble / delimiter search, then interleaved pairs
      if (byte_index == {6'd0, preamble_count}) begin
        if (rx_byte != DELIMITER) begin
          if (preamble_count == MAX_PREAMBLE) frame_mode_next = MODE_REJ;
          else preamble_count_next = preamble_count + 3'd1;
        end
      end else if (disc_off < 9'd16) begin
        if (!disc_off[0]) begin
          held_byte_next = rx_byte;
        end else if (disc_off < 9'd12) begin
          source_reg_next  = {source_reg[39:0], pair_val};
          running_sum_next = running_sum + {8'd0, pair_val} + {8'd0, BYTE_BIAS};
        end else begin
          received_checksum_next = {received_checksum[7:0], pair_val};
        end
      end
    end else if (mode_cur == MODE_MSG) begin
      if (byte_index == 9'd1 && rx_byte != SUB_START) begin
        frame_mode_next = MODE_REJ;
      end else begin
        if (byte_index == 9'd2) declared_length_next = rx_byte;
        if (byte_index >= 9'd3 && byte_index <= 9'd8)
          destination_reg_next = {destination_reg[39:0], rx_byte};
        if (byte_index >= 9'd9 && byte_index <= 9'd14)
          source_reg_next = {source_reg[39:0], rx_byte};
        if (byte_index >= 9'd15 && byte_index <= 9'd22)
          header_fields_next = {header_fields[55:0], rx_byte};
        if (byte_index == 9'd23) held_byte_next = rx_byte;
        if (byte_index < 9'd2 || byte_index < {1'b0, len_eff})
          running_sum_next = running_sum + {8'd0, rx_byte};
        // big-endian checksum just past the message
        if (len_eff >= 8'd3 && byte_index >= 9'd2) begin
          if (byte_index == {1'b0, len_eff})
            received_checksum_next = {rx_byte, 8'd0};
          if (byte_index == {1'b0, len_eff} + 9'd1)
            received_checksum_next = received_checksum | {8'd0, rx_byte};
        end
      end
    end
  end

  // Result for a frame ending on this byte
  assign disc_good = (frame_mode_next == MODE_DISC) &&
                     (byte_index > {6'd0, preamble_count_next}) &&
                     (frame_size > MIN_DISC_SIZE) &&
                     (frame_size >= {7'd0, preamble_count_next} + MIN_DISC_SIZE);
  assign msg_good  = (frame_mode_next == MODE_MSG) &&
                     (frame_size >= {2'd0, declared_length_next} + 10'd2) &&
                     (frame_size >= MSG_HDR_SIZE);

  always_comb begin
    result = '0;
    if (disc_good) begin
      result.frame_kind    = KIND_DISC;
      result.checksum_ok   = (running_sum_next == received_checksum_next);
      result.source_id     = source_reg_next;
      result.command_class = DISC_CMD_CLASS;
      result.parameter_id  = DISC_PARAM_ID;
    end else if (msg_good) begin
      result.frame_kind         = KIND_MSG;
      result.checksum_ok        = (declared_length_next >= 8'd3) &&
                                  (running_sum_next == received_checksum_next);
      result.source_id          = source_reg_next;
      result.destination_id     = destination_reg_next;
      result.transaction_number = header_fields_next[63:56];
      result.port_or_response   = header_fields_next[55:48];
      result.queued_count       = header_fields_next[47:40];
      result.subdevice_num      = header_fields_next[39:24];
      result.command_class      = header_fields_next[23:16];
      result.parameter_id       = header_fields_next[15:0];
      result.data_length        = held_byte_next;
    end
  end

  assign frame_done = accept && frame_last;

  // State registers: cleared at reset and after every frame
  always_ff @(posedge clk) begin
    if (rst || frame_done) begin
      frame_mode        <= MODE_IDLE;
      byte_index        <= '0;
      preamble_count    <= '0;
      running_sum       <= '0;
      declared_length   <= '0;
      received_checksum <= '0;
      held_byte         <= '0;
      source_reg        <= '0;
      destination_reg   <= '0;
      header_fields     <= '0;
    end else if (accept) begin
      frame_mode        <= frame_mode_next;
      if (byte_index != INDEX_MAX) byte_index <= byte_index + 9'd1;
      preamble_count    <= preamble_count_next;
      running_sum       <= running_sum_next;
      declared_length   <= declared_length_next;
      received_checksum <= received_checksum_next;
      held_byte         <= held_byte_next;
      source_reg        <= source_reg_next;
      destination_reg   <= destination_reg_next;
      header_fields     <= header_fields_next;
    end
  end

  // every frame starts from a clean tracker
  `RDM_ASSERT_NXT(a_clear_after_last, clk, rst, frame_done,
                  frame_mode == MODE_IDLE && byte_index == 9'd0 && running_sum == 16'd0)
  // once a start code is seen, the counter has moved on
  `RDM_ASSERT_IMP(a_mode_has_index, clk, rst, frame_mode != MODE_IDLE, byte_index != 9'd0)
  // preamble never runs ahead of the byte counter
  `RDM_ASSERT_IMP(a_preamble_bound, clk, rst, 1'b1, ({6'd0, preamble_count} <= byte_index))

endmodule

// File: sv/rdm_frame_parser.sv
// Top level: lighting-bus management frame parser with registered result.
//
// Takes one frame byte per cycle on byte_in (frame_last on the final byte)
// and gives one result item per frame on result_out, in the cycle after the
// last byte is taken. Each byte goes through a single layer of logic between
// the frame state registers and the result register, so a byte is accepted
// every cycle; byte_in only stalls while a finished result waits on
// result_out and the consumer holds ready low. Discovery responses report
// their decoded ID, standard messages their header fields; unrecognised,
// malformed or short frames give frame_kind 0 with all fields zero.
`timescale 1ns / 1ps
`include "rdm_frame_parser_defines.svh"
module rdm_frame_parser (
  input  logic         clk,
  input  logic         rst,
  rdm_byte_if.sink     byte_in,
  rdm_result_if.source result_out
);
  import rdm_pkg::*;

  logic        in_accept;
  logic        frame_done;
  rdm_result_t frame_result;
  rdm_result_t res_q;
  logic        out_valid;

  // Accept whenever the result register is free or being emptied
  assign byte_in.ready = !out_valid || result_out.ready;
  assign in_accept     = byte_in.valid && byte_in.ready;

  rdm_frame_track u_track (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .rx_byte    (byte_in.rx_byte),
    .frame_last (byte_in.frame_last),
    .frame_done (frame_done),
    .result     (frame_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_done) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) res_q <= frame_result;
  end

  assign result_out.valid              = out_valid;
  assign result_out.frame_kind         = res_q.frame_kind;
  assign result_out.checksum_ok        = res_q.checksum_ok;
  assign result_out.source_id          = res_q.source_id;
  assign result_out.destination_id     = res_q.destination_id;
  assign result_out.transaction_number = res_q.transaction_number;
  assign result_out.port_or_response   = res_q.port_or_response;
  assign result_out.queued_count       = res_q.queued_count;
  assign result_out.subdevice_num      = res_q.subdevice_num;
  assign result_out.command_class      = res_q.command_class;
  assign result_out.parameter_id       = res_q.parameter_id;
  assign result_out.data_length        = res_q.data_length;

  // a finished frame always lands in the result register
  `RDM_ASSERT_NXT(a_last_gives_result, clk, rst, frame_done, out_valid)
  // discovery results carry the fixed command and no target
  `RDM_ASSERT_IMP(a_disc_fixed, clk, rst, out_valid && res_q.frame_kind == KIND_DISC,
                  res_q.command_class == DISC_CMD_CLASS &&
                  res_q.parameter_id == DISC_PARAM_ID && res_q.destination_id == 48'd0)
  // rejected frames report nothing
  `RDM_ASSERT_IMP(a_reject_empty, clk, rst, out_valid && res_q.frame_kind == KIND_REJECT,
                  !res_q.checksum_ok && res_q.source_id == 48'd0)

endmodule
